/* sv/mct_pkg.sv */
package mct_pkg;

  // decoder token limit and result list size
  localparam int MAX_SYMBOLS = 7;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int CODE_W      = 7;
  localparam int CLEN_W      = 3;
  localparam int NUM_CODES   = 54;

  // configuration port
  localparam int          PADDR_W       = 3;
  localparam int          PDATA_W       = 32;
  localparam logic        REG_DIRECTION = 1'b0;
  localparam logic        DIR_ENCODE    = 1'b0;
  localparam logic        DIR_DECODE    = 1'b1;

  // symbol bytes
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_LOW_A = 8'd97;
  localparam logic [7:0] CH_LOW_Z = 8'd122;
  localparam logic [7:0] CASE_OFS = 8'd32;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } mct_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_invalid;
    logic       out_last;
  } mct_out_t;

  // code is written first symbol at the msb, left aligned, 1 = dash
  typedef struct packed {
    logic [7:0]        ch;
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] code;
  } mct_entry_t;

  typedef struct packed {
    logic              hit;
    logic [7:0]        ch;
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] code;
  } mct_hit_t;

  localparam mct_entry_t CODE_TABLE [NUM_CODES] = '{
    '{"A", 3'd2, 7'b0100000}, '{"B", 3'd4, 7'b1000000}, '{"C", 3'd4, 7'b1010000},
    '{"D", 3'd3, 7'b1000000}, '{"E", 3'd1, 7'b0000000}, '{"F", 3'd4, 7'b0010000},
    '{"G", 3'd3, 7'b1100000}, '{"H", 3'd4, 7'b0000000}, '{"I", 3'd2, 7'b0000000},
    '{"J", 3'd4, 7'b0111000}, '{"K", 3'd3, 7'b1010000}, '{"L", 3'd4, 7'b0100000},
    '{"M", 3'd2, 7'b1100000}, '{"N", 3'd2, 7'b1000000}, '{"O", 3'd3, 7'b1110000},
    '{"P", 3'd4, 7'b0110000}, '{"Q", 3'd4, 7'b1101000}, '{"R", 3'd3, 7'b0100000},
    '{"S", 3'd3, 7'b0000000}, '{"T", 3'd1, 7'b1000000}, '{"U", 3'd3, 7'b0010000},
    '{"V", 3'd4, 7'b0001000}, '{"W", 3'd3, 7'b0110000}, '{"X", 3'd4, 7'b1001000},
    '{"Y", 3'd4, 7'b1011000}, '{"Z", 3'd4, 7'b1100000},
    '{"0", 3'd5, 7'b1111100}, '{"1", 3'd5, 7'b0111100}, '{"2", 3'd5, 7'b0011100},
    '{"3", 3'd5, 7'b0001100}, '{"4", 3'd5, 7'b0000100}, '{"5", 3'd5, 7'b0000000},
    '{"6", 3'd5, 7'b1000000}, '{"7", 3'd5, 7'b1100000}, '{"8", 3'd5, 7'b1110000},
    '{"9", 3'd5, 7'b1111000},
    '{".", 3'd6, 7'b0101010}, '{",", 3'd6, 7'b1100110}, '{"?", 3'd6, 7'b0011000},
    '{"'", 3'd6, 7'b0111100}, '{"!", 3'd6, 7'b1010110}, '{"/", 3'd5, 7'b1001000},
    '{"(", 3'd5, 7'b1011000}, '{")", 3'd6, 7'b1011010}, '{"&", 3'd5, 7'b0100000},
    '{":", 3'd6, 7'b1110000}, '{";", 3'd6, 7'b1010100}, '{"=", 3'd5, 7'b1000100},
    '{"+", 3'd5, 7'b0101000}, '{"-", 3'd6, 7'b1000010}, '{"_", 3'd6, 7'b0011010},
    '{"\"", 3'd6, 7'b0100100}, '{"$", 3'd7, 7'b0001001}, '{"@", 3'd6, 7'b0110100}
  };

  // character to code, first table match wins
  function automatic mct_hit_t enc_lookup(logic [7:0] u);
    mct_hit_t r;
    r = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (CODE_TABLE[i].ch == u) begin
        r = '{1'b1, CODE_TABLE[i].ch, CODE_TABLE[i].len, CODE_TABLE[i].code};
      end
    end
    return r;
  endfunction

  // code to character, first table match wins
  function automatic mct_hit_t dec_lookup(logic [CLEN_W-1:0] len, logic [CODE_W-1:0] code);
    mct_hit_t r;
    r = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (CODE_TABLE[i].len == len && CODE_TABLE[i].code == code) begin
        r = '{1'b1, CODE_TABLE[i].ch, CODE_TABLE[i].len, CODE_TABLE[i].code};
      end
    end
    return r;
  endfunction

endpackage

/* sv/morse_code_translator.sv */
// Morse code text codec over a byte stream.
// Input channel in_valid/in_stall/in_item carries one byte plus an end of text
// flag; the result channel out_valid/out_stall/out_item carries one byte per
// result, an invalid flag and out_last on the final result of an item.
// The direction register (address 0 of the APB port) selects encode (0) or
// decode (1); write it only while the block is idle.
// An accepted item is registered in the input register, is translated in one
// pass into the result buffer once that buffer is free, and its first result
// shows on the port the cycle after that. The buffer hands out one result per
// cycle while the receiver does not stall: an encoded character has up to 8
// results (seven symbols and a space), a decode item 1 or 0. Items with one
// result each stream at one per cycle while the receiver does not stall.
// While the receiver stalls, the current result holds, one more item waits
// in the input register and in_stall rises once that register is full.
// Reset empties both registers, clears the decoder token and selects encode.
// The decoder token is kept across direction changes.
module morse_code_translator #(
  parameter int MAX_SYMBOLS = mct_pkg::MAX_SYMBOLS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mct_pkg::mct_in_t             in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mct_pkg::mct_out_t            out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mct_pkg::PADDR_W-1:0]  paddr,
  input  logic [mct_pkg::PDATA_W-1:0]  pwdata,
  output logic [mct_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int LW = $clog2(MAX_SYMBOLS + 1);
  localparam int PW = (MAX_SYMBOLS > mct_pkg::CODE_W) ? MAX_SYMBOLS : mct_pkg::CODE_W;

  logic                    dir_r;
  logic                    in_vld_r;
  mct_pkg::mct_in_t        in_item_r;
  logic [MAX_SYMBOLS-1:0]  pat_r, pat_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic                    slash_r, slash_nxt;
  logic                    bad_r, bad_nxt;
  logic                    open_r, open_nxt;
  logic [mct_pkg::MAX_RESULTS-1:0][7:0] bytes_r, bytes_nxt;
  logic [mct_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                                 inv_r, inv_nxt;

  logic              reg_sel;
  logic              take;
  logic              buf_free;
  logic              adv;
  logic              accept;
  logic [7:0]        c;
  logic [7:0]        u;
  mct_pkg::mct_hit_t enc_hit;
  mct_pkg::mct_hit_t dec_hit;

  // absorbed token and the token that gets closed
  logic [MAX_SYMBOLS-1:0]     a_pat;
  logic [LW-1:0]              a_len;
  logic                       a_slash, a_bad;
  logic [MAX_SYMBOLS-1:0]     k_pat;
  logic [LW-1:0]              k_len;
  logic                       k_slash, k_bad;
  logic [PW-1:0]              k_ext;
  logic [mct_pkg::CODE_W-1:0] k_code;
  logic                       do_close;
  logic                       tok_valid;
  logic [7:0]                 tok_char;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[mct_pkg::PADDR_W-1:2] == mct_pkg::REG_DIRECTION);
  assign prdata  = reg_sel ? {{(mct_pkg::PDATA_W-1){1'b0}}, dir_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= mct_pkg::DIR_ENCODE;
    end else if (psel && penable && pwrite && reg_sel) begin
      dir_r <= pwdata[0];
    end
  end

  // handshake between input register and result buffer
  assign take     = out_valid && !out_stall;
  assign buf_free = (cnt_r == '0) || ((cnt_r == mct_pkg::CNT_W'(1)) && take);
  assign adv      = in_vld_r && buf_free;
  assign in_stall = in_vld_r && !buf_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
  end

  // encoder lookup on the case-folded byte
  assign c       = in_item_r.char_in;
  assign u       = (c >= mct_pkg::CH_LOW_A && c <= mct_pkg::CH_LOW_Z) ? c - mct_pkg::CASE_OFS : c;
  assign enc_hit = mct_pkg::enc_lookup(u);

  // decoder: absorb one symbol byte into the token
  always_comb begin
    a_pat   = pat_r;
    a_len   = len_r;
    a_slash = slash_r;
    a_bad   = bad_r;
    if (!bad_r) begin
      if (c == mct_pkg::CH_SLASH) begin
        if (len_r == '0 && !slash_r) a_slash = 1'b1;
        else                          a_bad   = 1'b1;
      end else if (c == mct_pkg::CH_DOT || c == mct_pkg::CH_DASH) begin
        if (slash_r || len_r >= LW'(MAX_SYMBOLS)) begin
          a_bad = 1'b1;
        end else begin
          for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (c == mct_pkg::CH_DASH && len_r == LW'(i)) a_pat[i] = 1'b1;
          end
          a_len = len_r + LW'(1);
        end
      end else begin
        a_bad = 1'b1;
      end
    end
  end

  // decoder: pick the token to close and look it up
  always_comb begin
    if (c == mct_pkg::CH_SPACE) begin
      k_pat    = pat_r;
      k_len    = len_r;
      k_slash  = slash_r;
      k_bad    = bad_r;
      do_close = 1'b1;
    end else begin
      k_pat    = a_pat;
      k_len    = a_len;
      k_slash  = a_slash;
      k_bad    = a_bad;
      do_close = in_item_r.end_of_text;
    end
    k_ext = PW'(k_pat);
    for (int i = 0; i < mct_pkg::CODE_W; i++) begin
      k_code[mct_pkg::CODE_W-1-i] = k_ext[i];
    end
    dec_hit = mct_pkg::dec_lookup(k_len[mct_pkg::CLEN_W-1:0], k_code);
    tok_valid = 1'b0;
    tok_char  = 8'd0;
    if (!k_bad) begin
      if (k_slash) begin
        tok_valid = 1'b1;
        tok_char  = mct_pkg::CH_SPACE;
      end else if (k_len != '0 && k_len <= LW'(mct_pkg::CODE_W) && dec_hit.hit) begin
        tok_valid = 1'b1;
        tok_char  = dec_hit.ch;
      end
    end
  end

  // token state update
  always_comb begin
    pat_nxt   = pat_r;
    len_nxt   = len_r;
    slash_nxt = slash_r;
    bad_nxt   = bad_r;
    open_nxt  = open_r;
    if (adv && dir_r == mct_pkg::DIR_DECODE) begin
      if (do_close) begin
        pat_nxt   = '0;
        len_nxt   = '0;
        slash_nxt = 1'b0;
        bad_nxt   = 1'b0;
        open_nxt  = 1'b0;
      end else begin
        pat_nxt   = a_pat;
        len_nxt   = a_len;
        slash_nxt = a_slash;
        bad_nxt   = a_bad;
        open_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      len_r   <= '0;
      slash_r <= 1'b0;
      bad_r   <= 1'b0;
      open_r  <= 1'b0;
    end else begin
      pat_r   <= pat_nxt;
      len_r   <= len_nxt;
      slash_r <= slash_nxt;
      bad_r   <= bad_nxt;
      open_r  <= open_nxt;
    end
  end

  // result buffer: load a whole result list, then shift one out per take
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    inv_nxt   = inv_r;
    if (adv) begin
      bytes_nxt = '0;
      inv_nxt   = 1'b0;
      if (dir_r == mct_pkg::DIR_ENCODE) begin
        if (u == mct_pkg::CH_SPACE) begin
          bytes_nxt[0] = mct_pkg::CH_SLASH;
          bytes_nxt[1] = mct_pkg::CH_SPACE;
          cnt_nxt      = mct_pkg::CNT_W'(2);
        end else if (enc_hit.hit) begin
          for (int k = 0; k < mct_pkg::MAX_RESULTS; k++) begin
            if (k < mct_pkg::CODE_W && mct_pkg::CLEN_W'(k) < enc_hit.len) begin
              bytes_nxt[k] = enc_hit.code[mct_pkg::CODE_W-1-k] ? mct_pkg::CH_DASH
                                                                : mct_pkg::CH_DOT;
            end else if (k == int'(enc_hit.len)) begin
              bytes_nxt[k] = mct_pkg::CH_SPACE;
            end
          end
          cnt_nxt = mct_pkg::CNT_W'(enc_hit.len) + mct_pkg::CNT_W'(1);
        end else begin
          bytes_nxt[0] = c;
          cnt_nxt      = mct_pkg::CNT_W'(1);
        end
      end else begin
        bytes_nxt[0] = tok_char;
        inv_nxt      = !tok_valid;
        cnt_nxt      = do_close ? mct_pkg::CNT_W'(1) : '0;
      end
    end else if (take) begin
      bytes_nxt = {8'd0, bytes_r[mct_pkg::MAX_RESULTS-1:1]};
      cnt_nxt   = cnt_r - mct_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    inv_r   <= inv_nxt;
  end

  // result port
  assign out_valid            = (cnt_r != '0);
  assign out_item.out_char    = bytes_r[0];
  assign out_item.out_invalid = inv_r;
  assign out_item.out_last    = (cnt_r == mct_pkg::CNT_W'(1));

  // checks
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present right after reset");

  a_invalid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_invalid |-> out_item.out_last && out_item.out_char == 8'd0)
    else $error("invalid result is not a lone zero result");

  a_list_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.out_last |=> out_valid)
    else $error("result list broken before its last result");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 25;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT     = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam logic PHASE_DIR [6] = '{mct_pkg::DIR_DECODE, mct_pkg::DIR_ENCODE,
                                     mct_pkg::DIR_DECODE, mct_pkg::DIR_DECODE,
                                     mct_pkg::DIR_ENCODE, mct_pkg::DIR_DECODE};

  // every character the code table knows, space last
  localparam string CODE_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@ ";

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  mct_pkg::mct_in_t             in_item;
  logic                         out_valid;
  logic                         out_stall;
  mct_pkg::mct_out_t            out_item;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mct_pkg::PADDR_W-1:0]  paddr;
  logic [mct_pkg::PDATA_W-1:0]  pwdata;
  logic [mct_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  morse_code_translator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  // directed item table; typed rows carry their result text
  typedef struct {
    logic       dir;
    logic [7:0] ch;
    logic       eot;
    bit         typed;
    string      want;
    bit         want_inv;
  } script_row_t;

  script_row_t script [24] = '{
    '{mct_pkg::DIR_ENCODE, "E",   1'b0, 1'b1, ". ",       1'b0},
    '{mct_pkg::DIR_ENCODE, "e",   1'b0, 1'b1, ". ",       1'b0},
    '{mct_pkg::DIR_ENCODE, " ",   1'b0, 1'b1, "/ ",       1'b0},
    '{mct_pkg::DIR_ENCODE, "$",   1'b0, 1'b1, "...-..- ", 1'b0},
    '{mct_pkg::DIR_ENCODE, "6",   1'b0, 1'b1, "-.... ",   1'b0},
    '{mct_pkg::DIR_ENCODE, 8'h00, 1'b0, 1'b0, "",         1'b0},
    '{mct_pkg::DIR_ENCODE, 8'hFF, 1'b1, 1'b0, "",         1'b0},
    '{mct_pkg::DIR_DECODE, " ",   1'b0, 1'b1, "",         1'b1},
    '{mct_pkg::DIR_DECODE, "/",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, " ",   1'b0, 1'b1, " ",        1'b0},
    '{mct_pkg::DIR_DECODE, "-",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, ".",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, ".",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, ".",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, ".",   1'b1, 1'b1, "6",        1'b0},
    '{mct_pkg::DIR_DECODE, ".",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, " ",   1'b1, 1'b1, "E",        1'b0},
    '{mct_pkg::DIR_DECODE, "x",   1'b1, 1'b1, "",         1'b1},
    '{mct_pkg::DIR_DECODE, "/",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, "/",   1'b1, 1'b1, "",         1'b1},
    '{mct_pkg::DIR_DECODE, ".",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, ".",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, "-",   1'b0, 1'b1, "",         1'b0},
    '{mct_pkg::DIR_DECODE, "-",   1'b1, 1'b1, "",         1'b1}
  };

  // translator shadow state
  logic     dir_mode  = mct_pkg::DIR_ENCODE;
  string    tok_sym   = "";
  bit       tok_slash = 1'b0;
  bit       tok_bad   = 1'b0;
  bit       tok_open  = 1'b0;

  mct_pkg::mct_out_t item_out[$];
  mct_pkg::mct_out_t pending_out[$];
  int       fails     = 0;
  int       items_fed = 0;
  int       feed_calm = 0;
  int       cycles    = 0;

  // dots and dashes of one character, empty when unknown
  function automatic string morse_of(logic [7:0] c);
    case (c)
      "A": return ".-";      "B": return "-...";    "C": return "-.-.";
      "D": return "-..";     "E": return ".";       "F": return "..-.";
      "G": return "--.";     "H": return "....";    "I": return "..";
      "J": return ".---";    "K": return "-.-";     "L": return ".-..";
      "M": return "--";      "N": return "-.";      "O": return "---";
      "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
      "S": return "...";     "T": return "-";       "U": return "..-";
      "V": return "...-";    "W": return ".--";     "X": return "-..-";
      "Y": return "-.--";    "Z": return "--..";
      "0": return "-----";   "1": return ".----";   "2": return "..---";
      "3": return "...--";   "4": return "....-";   "5": return ".....";
      "6": return "-....";   "7": return "--...";   "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
      "'": return ".----.";  "!": return "-.-.--";  "/": return "-..-.";
      "(": return "-.--.";   ")": return "-.--.-";  "&": return ".-...";
      ":": return "---...";  ";": return "-.-.-.";  "=": return "-...-";
      "+": return ".-.-.";   "-": return "-....-";  "_": return "..--.-";
      "\"": return ".-..-."; "$": return "...-..-"; "@": return ".--.-.";
      " ": return "/";
      default: return "";
    endcase
  endfunction

  function automatic void put_out(logic [7:0] c, logic inv);
    item_out.push_back(mct_pkg::mct_out_t'{out_char: c, out_invalid: inv, out_last: 1'b0});
  endfunction

  // close the open token into one character or an invalid flag
  function automatic void close_tok();
    logic [7:0] ch;
    bit         ok;
    ch = 8'd0;
    ok = 1'b0;
    if (!tok_bad) begin
      if (tok_slash) begin
        ch = mct_pkg::CH_SPACE;
        ok = 1'b1;
      end else if (tok_sym.len() > 0) begin
        for (int i = 0; i < 256; i++) begin
          if (!ok && morse_of(8'(i)) == tok_sym) begin
            ch = 8'(i);
            ok = 1'b1;
          end
        end
      end
    end
    if (ok) put_out(ch, 1'b0);
    else put_out(8'd0, 1'b1);
    tok_sym   = "";
    tok_slash = 1'b0;
    tok_bad   = 1'b0;
    tok_open  = 1'b0;
  endfunction

  // results of one accepted item, with the token state advanced
  function automatic void translate_item(mct_pkg::mct_in_t it);
    logic [7:0] c;
    logic [7:0] u;
    string      code;
    item_out.delete();
    c = it.char_in;
    if (dir_mode == mct_pkg::DIR_ENCODE) begin
      u = (c >= mct_pkg::CH_LOW_A && c <= mct_pkg::CH_LOW_Z) ? c - mct_pkg::CASE_OFS : c;
      code = morse_of(u);
      if (code.len() == 0) begin
        put_out(c, 1'b0);
      end else begin
        for (int k = 0; k < code.len(); k++) put_out(code[k], 1'b0);
        put_out(mct_pkg::CH_SPACE, 1'b0);
      end
    end else if (c == mct_pkg::CH_SPACE) begin
      close_tok();
    end else begin
      tok_open = 1'b1;
      if (!tok_bad) begin
        if (c == mct_pkg::CH_SLASH) begin
          if (tok_sym.len() == 0 && !tok_slash) tok_slash = 1'b1;
          else tok_bad = 1'b1;
        end else if (c == mct_pkg::CH_DOT || c == mct_pkg::CH_DASH) begin
          if (tok_slash || tok_sym.len() >= mct_pkg::MAX_SYMBOLS) tok_bad = 1'b1;
          else if (c == mct_pkg::CH_DASH) tok_sym = {tok_sym, "-"};
          else tok_sym = {tok_sym, "."};
        end else begin
          tok_bad = 1'b1;
        end
      end
      if (it.end_of_text && tok_open) close_tok();
    end
    if (item_out.size() > 0) item_out[item_out.size() - 1].out_last = 1'b1;
  endfunction

  // idle cycles before the next item, with runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(5, 25);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // offer one item, wait for the handshake, queue what it must produce
  task automatic feed(logic [7:0] c, logic e, bit typed = 1'b0, string want = "",
                      bit want_inv = 1'b0);
    int               gap;
    mct_pkg::mct_in_t it;
    it.char_in     = c;
    it.end_of_text = e;
    gap = draw_wait(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    translate_item(it);
    if (!typed) begin
      foreach (item_out[i]) pending_out.push_back(item_out[i]);
    end else if (want_inv) begin
      pending_out.push_back(mct_pkg::mct_out_t'{out_char: 8'd0, out_invalid: 1'b1,
                                                out_last: 1'b1});
    end else begin
      for (int k = 0; k < want.len(); k++) begin
        pending_out.push_back(mct_pkg::mct_out_t'{out_char: want[k], out_invalid: 1'b0,
                                                  out_last: (k == want.len() - 1)});
      end
    end
    items_fed++;
  endtask

  // drain the block, then write the direction register
  task automatic set_direction(logic v);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mct_pkg::REG_DIRECTION, 2'b00};
    pwdata  <= mct_pkg::PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dir_mode = v;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, one long hold, field compare
  initial begin : result_side
    int                w;
    int                calm;
    int                seen;
    mct_pkg::mct_out_t got;
    mct_pkg::mct_out_t want;
    out_stall <= 1'b0;
    calm = 0;
    seen = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = (seen == HOLD_AT) ? HOLD_CYCLES : draw_wait(calm);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      seen++;
      got = out_item;
      if (pending_out.size() == 0) begin
        $error("unexpected item: out_char %0d out_invalid %0d out_last %0d",
               got.out_char, got.out_invalid, got.out_last);
        fails++;
      end else begin
        want = pending_out.pop_front();
        if (got.out_char !== want.out_char) begin
          $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
          fails++;
        end
        if (got.out_invalid !== want.out_invalid) begin
          $error("out_invalid: expected %0d, got %0d", want.out_invalid, got.out_invalid);
          fails++;
        end
        if (got.out_last !== want.out_last) begin
          $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
          fails++;
        end
      end
    end
  end

  // input side and run control
  initial begin : input_side
    int         phase_end;
    int         pick;
    bit         closer;
    string      code;
    logic [7:0] c;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_direction(mct_pkg::DIR_ENCODE);

    // directed rows
    foreach (script[r]) begin
      if (script[r].dir != dir_mode) set_direction(script[r].dir);
      feed(script[r].ch, script[r].eot, script[r].typed, script[r].want, script[r].want_inv);
    end

    // random phases, token state carried across direction writes
    for (int p = 0; p < $size(PHASE_DIR); p++) begin
      set_direction(PHASE_DIR[p]);
      phase_end = items_fed + PHASE_ITEMS;
      while (items_fed < phase_end) begin
        if (dir_mode == mct_pkg::DIR_ENCODE) begin
          if ($urandom_range(0, 2) == 0) c = 8'($urandom_range(0, 255));
          else c = CODE_CHARS[$urandom_range(0, CODE_CHARS.len() - 1)];
          if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + mct_pkg::CASE_OFS;
          feed(c, 1'($urandom_range(0, 1)));
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            // well-formed token closed by a space or by end of text
            code = morse_of(CODE_CHARS[$urandom_range(0, CODE_CHARS.len() - 1)]);
            closer = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < code.len(); k++) begin
              feed(code[k], closer && (k == code.len() - 1));
            end
            if (!closer) feed(mct_pkg::CH_SPACE, 1'($urandom_range(0, 1)));
          end else if (pick == 7) begin
            // overlong token
            repeat ($urandom_range(8, 10)) begin
              feed(($urandom_range(0, 1) == 1) ? mct_pkg::CH_DASH : mct_pkg::CH_DOT, 1'b0);
            end
            feed(mct_pkg::CH_SPACE, 1'b0);
          end else if (pick == 8) begin
            feed(($urandom_range(0, 1) == 1) ? mct_pkg::CH_SLASH : mct_pkg::CH_SPACE,
                 1'($urandom_range(0, 1)));
          end else begin
            feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
        end
      end
    end

    // drain and report
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mct_pkg.sv
sv/morse_code_translator.sv
test/tb.sv
